// File: src/linear_convolution_correlation_core_defines.svh
// Assertion helpers used by the core RTL file.
`ifndef LINEAR_CONVOLUTION_CORRELATION_CORE_DEFINES_SVH
`define LINEAR_CONVOLUTION_CORRELATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LCC_ASSERT_IMPL(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LCC_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: src/lcc_pkg.sv
`default_nettype none

package lcc_pkg;

	localparam int FUNC_W    = 2;
	localparam int IDX_W     = 5;
	localparam int LEN_W     = 6;
	localparam int OUT_IDX_W = 6;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// Input word kinds carried on tuser.
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SIG  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_RESP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_START     = 2'd2;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_SIG_LEN  = 2'd1;
	localparam logic [1:0] REG_RESP_LEN = 2'd2;

	localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// A length of zero runs as one; anything above the store depth runs as the depth.
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
		input logic [LEN_W-1:0] max_len);
		logic [LEN_W-1:0] res;
		if (len == '0) begin
			res = LEN_W'(1);
		end else if (len > max_len) begin
			res = max_len;
		end else begin
			res = len;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/lcc_ram.sv
`default_nettype none

module lcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/lcc_mac.sv
`default_nettype none

module lcc_mac #(
	parameter int SAMPLE_BITS = 16,
	parameter int SUM_W = 37
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lcc_pkg::mac_ctl_t       ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] a,
	input  wire logic signed [SAMPLE_BITS-1:0] b,
	output logic signed [SUM_W-1:0]      acc,
	output logic                         done
);

	localparam int PROD_W = 2 * SAMPLE_BITS;

	logic signed [PROD_W-1:0] prod_s2;
	lcc_pkg::mac_ctl_t        ctl_s2;
	logic signed [SUM_W-1:0]  prod_ext;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	assign prod_ext = {{(SUM_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	// The first term of an output sample restarts the sum.
	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: src/linear_convolution_correlation_core.sv
// Linear convolution and cross-correlation core.
// Input stream (s_*): tuser selects the word kind. Kind 0 writes a signal sample and kind 1
// a response sample at sample_index; a load gives no output.
// Kind 2 starts a run that emits one output word per index k = 0 .. N+M-2 on the
// master stream (m_*), with tlast on the final word. Kind 3 is dropped.
// Configuration goes through the APB port: mode (0 convolution, 1 correlation with the
// response reversed), signal length N and response length M.
// Each output sample walks its stored sample pairs through one shared multiply-accumulate
// unit, one pair per cycle, and passes the issue state, the registered store read, the
// product register, the accumulate and the emit. s_tready stays low until a run ends.
// The output register lets loads and the next start be accepted while the final word
// waits; if the receiver stalls, the core holds at the next output until it is taken.
// Reset clears the control state and sets mode 0 and both lengths to 32; the sample
// stores are not cleared and must be written before they are used.

`default_nettype none

`include "linear_convolution_correlation_core_defines.svh"

module linear_convolution_correlation_core #(
	parameter int MAX_LEN = 32,
	parameter int SAMPLE_BITS = 16,
	localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_LEN),
	localparam int IN_DATA_W = ((lcc_pkg::IDX_W + SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((lcc_pkg::OUT_IDX_W + SUM_W + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lcc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [lcc_pkg::APB_DW-1:0]    pwdata,
	output logic      [lcc_pkg::APB_DW-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// sample_index, sample_value, zero fill
	input  wire logic [IN_DATA_W-1:0]          s_tdata,
	// func
	input  wire logic [lcc_pkg::FUNC_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// output_index, sum_value, zero fill
	output logic      [OUT_DATA_W-1:0]         m_tdata,
	output logic                               m_tlast
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LEN_W = lcc_pkg::LEN_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	logic             mode_q;
	logic [LEN_W-1:0] sig_len_q;
	logic [LEN_W-1:0] resp_len_q;

	logic [LEN_W-1:0] k_q, j_q, jhi_q, n_q, m_q, kend_q;
	logic             first_q;

	logic [lcc_pkg::IDX_W-1:0]     in_idx;
	logic signed [SAMPLE_BITS-1:0] in_val;
	logic                          in_accept, idx_ok, sig_we, resp_we, start;
	logic [LEN_W-1:0]              n_clamp, m_clamp;
	logic [LEN_W-1:0]              k_nx, jlo_nx, jhi_nx, r_idx, resp_idx;

	logic signed [SAMPLE_BITS-1:0] sig_rdata, resp_rdata;
	lcc_pkg::mac_ctl_t             ctl_iss, ctl_s1;
	logic signed [SUM_W-1:0]       mac_acc;
	logic                          mac_done;

	logic                             out_valid_q, out_last_q, out_free, out_load;
	logic [lcc_pkg::OUT_IDX_W-1:0]    out_idx_q;
	logic signed [SUM_W-1:0]          out_sum_q;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			sig_len_q  <= lcc_pkg::LEN_RESET;
			resp_len_q <= lcc_pkg::LEN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				lcc_pkg::REG_MODE:     mode_q     <= pwdata[0];
				lcc_pkg::REG_SIG_LEN:  sig_len_q  <= pwdata[LEN_W-1:0];
				lcc_pkg::REG_RESP_LEN: resp_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lcc_pkg::REG_MODE:     prdata = lcc_pkg::APB_DW'(mode_q);
			lcc_pkg::REG_SIG_LEN:  prdata = lcc_pkg::APB_DW'(sig_len_q);
			lcc_pkg::REG_RESP_LEN: prdata = lcc_pkg::APB_DW'(resp_len_q);
			default:               prdata = '0;
		endcase
	end

	// Input decode
	assign in_idx    = s_tdata[lcc_pkg::IDX_W-1:0];
	assign in_val    = s_tdata[lcc_pkg::IDX_W +: SAMPLE_BITS];
	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign idx_ok    = LEN_W'(in_idx) < LEN_W'(MAX_LEN);
	assign sig_we    = in_accept && idx_ok && (s_tuser == lcc_pkg::FUNC_LOAD_SIG);
	assign resp_we   = in_accept && idx_ok && (s_tuser == lcc_pkg::FUNC_LOAD_RESP);
	assign start     = in_accept && (s_tuser == lcc_pkg::FUNC_START);

	assign n_clamp = lcc_pkg::clamp_len(sig_len_q, LEN_W'(MAX_LEN));
	assign m_clamp = lcc_pkg::clamp_len(resp_len_q, LEN_W'(MAX_LEN));

	// Pair range of the next output index: j runs from max(0, k-M+1) to min(N-1, k).
	assign k_nx   = k_q + LEN_W'(1);
	assign jlo_nx = (k_nx >= m_q) ? (k_nx - m_q + LEN_W'(1)) : '0;
	assign jhi_nx = (k_nx >= n_q - LEN_W'(1)) ? (n_q - LEN_W'(1)) : k_nx;

	// Correlation reads the response from its far end.
	assign r_idx    = k_q - j_q;
	assign resp_idx = mode_q ? (m_q - LEN_W'(1) - r_idx) : r_idx;

	lcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_sig_ram (
		.clk   (clk),
		.we    (sig_we),
		.waddr (in_idx[AW-1:0]),
		.wdata (in_val),
		.raddr (j_q[AW-1:0]),
		.rdata (sig_rdata)
	);

	lcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_resp_ram (
		.clk   (clk),
		.we    (resp_we),
		.waddr (in_idx[AW-1:0]),
		.wdata (in_val),
		.raddr (resp_idx[AW-1:0]),
		.rdata (resp_rdata)
	);

	assign ctl_iss.valid = (state_q == S_ISSUE);
	assign ctl_iss.first = first_q;
	assign ctl_iss.last  = (j_q == jhi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_iss;
		end
	end

	lcc_mac #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.a      (sig_rdata),
		.b      (resp_rdata),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == S_EMIT) && out_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			j_q     <= '0;
			jhi_q   <= '0;
			n_q     <= LEN_W'(1);
			m_q     <= LEN_W'(1);
			kend_q  <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q     <= '0;
						j_q     <= '0;
						jhi_q   <= '0;
						n_q     <= n_clamp;
						m_q     <= m_clamp;
						kend_q  <= n_clamp + m_clamp - LEN_W'(2);
						first_q <= 1'b1;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					first_q <= 1'b0;
					if (j_q == jhi_q) begin
						state_q <= S_WAIT;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				S_WAIT: begin
					if (mac_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (k_q == kend_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_nx;
							j_q     <= jlo_nx;
							jhi_q   <= jhi_nx;
							first_q <= 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= k_q;
			out_sum_q  <= mac_acc;
			out_last_q <= (k_q == kend_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_sum_q, out_idx_q});
	assign m_tlast  = out_last_q;

	`LCC_ASSERT_IMPL(a_done_in_wait, mac_done, state_q == S_WAIT, "sum finished outside wait")
	`LCC_ASSERT_IMPL(a_last_term_wait, ctl_s1.valid && ctl_s1.last, state_q == S_WAIT,
		"final pair read while still issuing")
	`LCC_ASSERT_IMPL(a_j_range, state_q == S_ISSUE, (j_q <= jhi_q) && (jhi_q < n_q),
		"pair index out of range")
	`LCC_ASSERT_IMPL(a_k_range, state_q != S_IDLE, k_q <= kend_q, "output index past end")

endmodule

`default_nettype wire

// File: bench/lcc_checker.sv
`default_nettype none

module lcc_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lcc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [lcc_pkg::APB_DW-1:0]    pwdata,
	input  wire logic [lcc_pkg::APB_DW-1:0]    prdata,
	input  wire logic                          pready,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	// sample_index, sample_value, zero fill
	input  wire logic [23:0]                   s_tdata,
	// func
	input  wire logic [lcc_pkg::FUNC_W-1:0]    s_tuser,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	// output_index, sum_value, zero fill
	input  wire logic [47:0]                   m_tdata,
	input  wire logic                          m_tlast,
	output int                                 errors,
	output int                                 pending,
	output int                                 checked
);

	localparam int DEPTH = 32;
	localparam int SUM_W = 37;

	typedef struct packed {
		logic [lcc_pkg::OUT_IDX_W-1:0] k;
		logic [SUM_W-1:0]              sum;
		logic                          last;
	} conv_word_t;

	conv_word_t                  conv_queue[$];
	logic signed [15:0]          sig_mem [DEPTH];
	logic signed [15:0]          resp_mem [DEPTH];
	logic                        corr_mode = 1'b0;
	logic [lcc_pkg::LEN_W-1:0]   sig_len = lcc_pkg::LEN_RESET;
	logic [lcc_pkg::LEN_W-1:0]   resp_len = lcc_pkg::LEN_RESET;

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic int active_len(input logic [lcc_pkg::LEN_W-1:0] len);
		if (len == '0) begin
			return 1;
		end
		if (int'(len) > DEPTH) begin
			return DEPTH;
		end
		return int'(len);
	endfunction

	// Every output index of the full linear convolution, with the response
	// read backward in correlation mode.
	task automatic queue_conv_run();
		int n;
		int m;
		int r;
		longint acc;
		logic signed [15:0] tap;
		conv_word_t w;
		n = active_len(sig_len);
		m = active_len(resp_len);
		for (int k = 0; k < n + m - 1; k++) begin
			acc = 0;
			for (int j = 0; j < n; j++) begin
				r = k - j;
				if (r >= 0 && r < m) begin
					tap = corr_mode ? resp_mem[m - 1 - r] : resp_mem[r];
					acc += longint'(sig_mem[j]) * longint'(tap);
				end
			end
			w.k = lcc_pkg::OUT_IDX_W'(k);
			w.sum = acc[SUM_W-1:0];
			w.last = (k == n + m - 2);
			conv_queue.push_back(w);
		end
	endtask

	always @(posedge clk) begin : watch
		logic [lcc_pkg::APB_DW-1:0]    reg_val;
		logic [lcc_pkg::OUT_IDX_W-1:0] got_k;
		logic [SUM_W-1:0]              got_sum;
		conv_word_t                    want;
		if (!arst_n) begin
			corr_mode = 1'b0;
			sig_len = lcc_pkg::LEN_RESET;
			resp_len = lcc_pkg::LEN_RESET;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						lcc_pkg::REG_MODE:     corr_mode = pwdata[0];
						lcc_pkg::REG_SIG_LEN:  sig_len = pwdata[lcc_pkg::LEN_W-1:0];
						lcc_pkg::REG_RESP_LEN: resp_len = pwdata[lcc_pkg::LEN_W-1:0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						lcc_pkg::REG_MODE:     reg_val = {31'b0, corr_mode};
						lcc_pkg::REG_SIG_LEN:  reg_val = {26'b0, sig_len};
						lcc_pkg::REG_RESP_LEN: reg_val = {26'b0, resp_len};
						default:               reg_val = prdata;
					endcase
					if (prdata !== reg_val) begin
						report($sformatf("register %0d read 0x%0h, expected 0x%0h",
							paddr[3:2], prdata, reg_val));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					lcc_pkg::FUNC_LOAD_SIG:  sig_mem[s_tdata[4:0]] = s_tdata[20:5];
					lcc_pkg::FUNC_LOAD_RESP: resp_mem[s_tdata[4:0]] = s_tdata[20:5];
					lcc_pkg::FUNC_START:     queue_conv_run();
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_k = m_tdata[lcc_pkg::OUT_IDX_W-1:0];
				got_sum = m_tdata[lcc_pkg::OUT_IDX_W+SUM_W-1:lcc_pkg::OUT_IDX_W];
				if (conv_queue.size() == 0) begin
					report($sformatf("output word k=%0d arrived with no result pending", got_k));
				end else begin
					want = conv_queue.pop_front();
					if (got_k !== want.k) begin
						report($sformatf("output index %0d, expected %0d", got_k, want.k));
					end
					if (got_sum !== want.sum) begin
						report($sformatf("k=%0d sum %0d, expected %0d", want.k,
							$signed(got_sum), $signed(want.sum)));
					end
					if (m_tlast !== want.last) begin
						report($sformatf("k=%0d tlast %b, expected %b", want.k, m_tlast,
							want.last));
					end
					checked++;
				end
			end
		end
		pending = conv_queue.size();
	end

endmodule

`default_nettype wire

// File: bench/tb_linear_convolution_correlation_core.sv
`default_nettype none

module tb_linear_convolution_correlation_core;

	localparam int LIMIT = 2500000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 25;
	localparam logic [lcc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [lcc_pkg::APB_AW-1:0]        paddr;
	logic [lcc_pkg::APB_DW-1:0]        pwdata;
	logic [lcc_pkg::APB_DW-1:0]        prdata;
	logic                              pready;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [23:0]                       s_tdata;
	logic [lcc_pkg::FUNC_W-1:0]        s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [47:0]                       m_tdata;
	logic                              m_tlast;

	int errors;
	int pending;
	int checked;
	int cycles = 0;
	int words_sent = 0;
	int runs_started = 0;
	int settings_used = 0;
	bit gaps_on = 1'b1;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic [lcc_pkg::LEN_W-1:0] cur_sig_len = lcc_pkg::LEN_RESET;
	logic [lcc_pkg::LEN_W-1:0] cur_resp_len = lcc_pkg::LEN_RESET;

	linear_convolution_correlation_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	lcc_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("linear_convolution_correlation_core regression: fail");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(gaps_on && $urandom_range(99) < 15);
			end
		end
	end

	function automatic int live_len(input logic [lcc_pkg::LEN_W-1:0] len);
		if (len == '0) begin
			return 1;
		end
		if (int'(len) > 32) begin
			return 32;
		end
		return int'(len);
	endfunction

	function automatic logic [lcc_pkg::LEN_W-1:0] pick_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60) begin
			return lcc_pkg::LEN_W'($urandom_range(8, 1));
		end else if (roll < 75) begin
			return lcc_pkg::LEN_W'($urandom_range(31, 9));
		end else if (roll < 87) begin
			return lcc_pkg::LEN_W'(32);
		end else if (roll < 94) begin
			return '0;
		end
		return lcc_pkg::LEN_W'($urandom_range(63, 33));
	endfunction

	task automatic send_word(input logic [lcc_pkg::FUNC_W-1:0] f,
		input logic [lcc_pkg::IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {3'b000, val, idx};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (f == lcc_pkg::FUNC_START) begin
			runs_started++;
		end
	endtask

	task automatic send_start();
		send_word(lcc_pkg::FUNC_START, lcc_pkg::IDX_W'($urandom_range(31)),
			16'($urandom_range(65535)));
	endtask

	// Wait until every result has arrived and the core has had time to settle.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] ridx,
		input logic [lcc_pkg::APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {ridx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic mode, input logic [lcc_pkg::LEN_W-1:0] sig_len,
		input logic [lcc_pkg::LEN_W-1:0] resp_len);
		apb_xfer(1'b1, lcc_pkg::REG_MODE, {31'b0, mode});
		apb_xfer(1'b1, lcc_pkg::REG_SIG_LEN, {26'b0, sig_len});
		apb_xfer(1'b1, lcc_pkg::REG_RESP_LEN, {26'b0, resp_len});
		apb_xfer(1'b0, lcc_pkg::REG_MODE, '0);
		apb_xfer(1'b0, lcc_pkg::REG_SIG_LEN, '0);
		apb_xfer(1'b0, lcc_pkg::REG_RESP_LEN, '0);
		cur_sig_len = sig_len;
		cur_resp_len = resp_len;
		settings_used++;
	endtask

	initial begin
		int budget;
		int roll;
		int loads;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lcc_pkg::FUNC_LOAD_SIG;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill both stores with the most negative sample, so that the run under the
		// reset setting gives the largest possible sums and no run reads an empty entry.
		for (int i = 0; i < 32; i++) begin
			send_word(lcc_pkg::FUNC_LOAD_SIG, lcc_pkg::IDX_W'(i), 16'h8000);
			send_word(lcc_pkg::FUNC_LOAD_RESP, lcc_pkg::IDX_W'(i), 16'h8000);
		end
		send_start();
		wait_idle();
		set_config(1'b1, lcc_pkg::LEN_W'(32), lcc_pkg::LEN_W'(32));
		send_start();
		wait_idle();
		set_config(1'b0, lcc_pkg::LEN_W'(3), lcc_pkg::LEN_W'(2));
		send_word(lcc_pkg::FUNC_LOAD_SIG, lcc_pkg::IDX_W'(0), 16'h7FFF);
		send_word(lcc_pkg::FUNC_LOAD_SIG, lcc_pkg::IDX_W'(1), 16'h8000);
		send_word(lcc_pkg::FUNC_LOAD_SIG, lcc_pkg::IDX_W'(2), 16'h0001);
		send_word(lcc_pkg::FUNC_LOAD_RESP, lcc_pkg::IDX_W'(0), 16'h8000);
		send_word(lcc_pkg::FUNC_LOAD_RESP, lcc_pkg::IDX_W'(1), 16'h7FFF);
		send_start();
		send_word(FUNC_UNUSED, lcc_pkg::IDX_W'(31), 16'hFFFF);
		wait_idle();
		set_config(1'b1, lcc_pkg::LEN_W'(3), lcc_pkg::LEN_W'(2));
		send_start();
		wait_idle();
		// Zero runs as one and anything past the store depth runs as the depth.
		set_config(1'b0, lcc_pkg::LEN_W'(0), lcc_pkg::LEN_W'(63));
		send_start();
		wait_idle();
		set_config(1'b1, lcc_pkg::LEN_W'(63), lcc_pkg::LEN_W'(0));
		send_start();
		wait_idle();
		set_config(1'b0, lcc_pkg::LEN_W'(1), lcc_pkg::LEN_W'(1));
		send_start();

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			gaps_on = (ph != 4);
			set_config(1'($urandom_range(1)), pick_len(), pick_len());
			if (ph == 2) begin
				hold_reqs++;
			end
			budget = PHASE_ITEMS;
			while (budget > 0) begin
				roll = $urandom_range(99);
				if (roll < 10) begin
					send_word(FUNC_UNUSED, lcc_pkg::IDX_W'($urandom_range(31)),
						16'($urandom_range(65535)));
				end else if (roll < 25) begin
					send_word($urandom_range(1) ? lcc_pkg::FUNC_LOAD_RESP :
						lcc_pkg::FUNC_LOAD_SIG,
						lcc_pkg::IDX_W'($urandom_range(31)), 16'($urandom_range(65535)));
					budget--;
				end else begin
					// A few loads inside the live part of the stores, then a start.
					loads = $urandom_range(3);
					repeat (loads) begin
						if ($urandom_range(1)) begin
							send_word(lcc_pkg::FUNC_LOAD_SIG,
								lcc_pkg::IDX_W'($urandom_range(live_len(cur_sig_len) - 1)),
								16'($urandom_range(65535)));
						end else begin
							send_word(lcc_pkg::FUNC_LOAD_RESP,
								lcc_pkg::IDX_W'($urandom_range(live_len(cur_resp_len) - 1)),
								16'($urandom_range(65535)));
						end
						budget--;
					end
					send_start();
					budget--;
				end
			end
		end
		wait_idle();

		$display("covered %0d input words and %0d runs over %0d register settings",
			words_sent, runs_started, settings_used);
		$display("checked %0d output words in %0d cycles", checked, cycles);
		if (errors == 0 && pending == 0) begin
			$display("linear_convolution_correlation_core regression: pass");
		end else begin
			$display("linear_convolution_correlation_core regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/lcc_pkg.sv
src/lcc_ram.sv
src/lcc_mac.sv
src/linear_convolution_correlation_core.sv
bench/lcc_checker.sv
bench/tb_linear_convolution_correlation_core.sv
